FILE: hw/rtl/tagged_btb_two_bit_predictor_top_assert.svh
// Assertion macros for the tagged BTB predictor.
// Used by the top level; no other dependencies.
`ifndef TAGGED_BTB_TWO_BIT_PREDICTOR_TOP_ASSERT_SVH
`define TAGGED_BTB_TWO_BIT_PREDICTOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define TBTB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define TBTB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/tbtb_pkg.sv
// Package for the tagged BTB predictor: sizes, table entry, control structs.
// No dependencies.
`default_nettype none

package tbtb_pkg;

   // Table size; must be a power of two so the index is the low address bits.
   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int ADDR_W = 64;
   localparam int CNT_W  = 32;
   localparam int CTR_W  = 2;

   localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;
   localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;

   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] tag;
      logic [CTR_W-1:0]  ctr;
      cnt_type           evictions;
   } entry_type;

   // Controller -> datapath
   typedef struct packed {
      logic clear;    // write zero entry at sweep index
      logic capture;  // accept request word, start table read
      logic commit;   // write back entry, load response register
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic clear_last;  // sweep at final entry
      logic out_free;    // response register can take a word
   } status_type;

   typedef struct packed {
      logic    predicted_taken;
      logic    hit;
      logic    prediction_correct;
      logic    evicted;
      cnt_type seen_total;
      cnt_type taken_total;
      cnt_type correct_total;
      cnt_type evicted_total;
      cnt_type entry_evictions;
   } rsp_type;

   function automatic cnt_type sat_inc(input cnt_type v);
      sat_inc = (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tbtb_if.sv
// Request and response channel interfaces for the tagged BTB predictor.
// Depends on tbtb_pkg.
`default_nettype none

interface tbtb_req_if
   import tbtb_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] branch_address;
   logic              taken;

   modport source (output valid, output branch_address, output taken, input ready);
   modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

interface tbtb_rsp_if
   import tbtb_pkg::*;
   ;
   logic    valid;
   logic    ready;
   logic    predicted_taken;
   logic    hit;
   logic    prediction_correct;
   logic    evicted;
   cnt_type seen_total;
   cnt_type taken_total;
   cnt_type correct_total;
   cnt_type evicted_total;
   cnt_type entry_evictions;

   modport source (output valid, output predicted_taken, output hit,
                   output prediction_correct, output evicted, output seen_total,
                   output taken_total, output correct_total, output evicted_total,
                   output entry_evictions, input ready);
   modport sink   (input valid, input predicted_taken, input hit,
                   input prediction_correct, input evicted, input seen_total,
                   input taken_total, input correct_total, input evicted_total,
                   input entry_evictions, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tbtb_ctrl.sv
// Controller FSM for the tagged BTB predictor: clear sweep, accept, commit.
// Depends on tbtb_pkg.
`default_nettype none

module tbtb_ctrl
   import tbtb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // hold until the response register frees up
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/tbtb_datapath.sv
// Datapath for the tagged BTB predictor: entry table, update logic, totals,
// response register. Depends on tbtb_pkg.
`default_nettype none

module tbtb_datapath
   import tbtb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire logic [ADDR_W-1:0] req_branch_address,
   input  wire logic              req_taken,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output rsp_type                rsp_word
);

   entry_type mem [TABLE_ENTRIES];

   logic [ADDR_W-1:0] addr_ff;
   logic              taken_ff;
   entry_type         rd_ff;
   logic [IDX_W-1:0]  clr_idx_ff, clr_idx_in;
   cnt_type           seen_ff, seen_in;
   cnt_type           taken_cnt_ff, taken_cnt_in;
   cnt_type           correct_ff, correct_in;
   cnt_type           evict_ff, evict_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic [IDX_W-1:0]  idx;
   logic              hit;
   logic              pred;
   logic              correct;
   logic              evict;
   logic [CTR_W-1:0]  ctr_upd;
   entry_type         new_entry;

   assign idx = addr_ff[IDX_W-1:0];

   always_comb begin
      hit  = rd_ff.valid && (rd_ff.tag == addr_ff);
      pred = hit && (rd_ff.ctr > 2'd1);
      if (taken_ff) begin
         ctr_upd = (rd_ff.ctr == CTR_MAX) ? rd_ff.ctr : rd_ff.ctr + 1'b1;
      end else begin
         ctr_upd = (rd_ff.ctr == CTR_MIN) ? rd_ff.ctr : rd_ff.ctr - 1'b1;
      end
      evict   = !hit && taken_ff && rd_ff.valid;
      correct = (pred == taken_ff);

      new_entry = rd_ff;
      if (hit) begin
         new_entry.ctr = ctr_upd;
      end else if (taken_ff) begin
         // install keeps the old counter
         new_entry.valid = 1'b1;
         new_entry.tag   = addr_ff;
      end
      if (evict) begin
         new_entry.evictions = sat_inc(rd_ff.evictions);
      end

      seen_in      = seen_ff;
      taken_cnt_in = taken_cnt_ff;
      correct_in   = correct_ff;
      evict_in     = evict_ff;
      if (cmd.commit) begin
         seen_in = sat_inc(seen_ff);
         if (taken_ff) taken_cnt_in = sat_inc(taken_cnt_ff);
         if (correct)  correct_in   = sat_inc(correct_ff);
         if (evict)    evict_in     = sat_inc(evict_ff);
      end

      out_in                    = out_ff;
      out_valid_in              = out_valid_ff && !rsp_ready;
      if (cmd.commit) begin
         out_valid_in              = 1'b1;
         out_in.predicted_taken    = pred;
         out_in.hit                = hit;
         out_in.prediction_correct = correct;
         out_in.evicted            = evict;
         out_in.seen_total         = seen_in;
         out_in.taken_total        = taken_cnt_in;
         out_in.correct_total      = correct_in;
         out_in.evicted_total      = evict_in;
         out_in.entry_evictions    = new_entry.evictions;
      end

      clr_idx_in = cmd.clear ? clr_idx_ff + 1'b1 : clr_idx_ff;
   end

   // table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_idx_ff] <= '0;
      end else if (cmd.commit) begin
         mem[idx] <= new_entry;
      end
      if (cmd.capture) begin
         rd_ff <= mem[req_branch_address[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff  <= req_branch_address;
         taken_ff <= req_taken;
      end
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff   <= '0;
         seen_ff      <= '0;
         taken_cnt_ff <= '0;
         correct_ff   <= '0;
         evict_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_idx_ff   <= clr_idx_in;
         seen_ff      <= seen_in;
         taken_cnt_ff <= taken_cnt_in;
         correct_ff   <= correct_in;
         evict_ff     <= evict_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.clear_last = (clr_idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign status.out_free   = !out_valid_ff || rsp_ready;
   assign rsp_valid         = out_valid_ff;
   assign rsp_word          = out_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tagged_btb_two_bit_predictor_top.sv
// Top level of the tagged BTB with two-bit bimodal predictor.
// Depends on tbtb_pkg, tbtb_if, tbtb_ctrl, tbtb_datapath and the assert header.
//
// Usage:
//  - req_if carries one resolved branch per word: branch_address and taken.
//    A word is taken when valid and ready are both high at a clock edge.
//  - rsp_if returns one word per request: prediction, hit, correctness,
//    eviction flag, four saturating 32-bit totals and the entry's
//    eviction count.
//  - Response: the request edge reads the table into rd_ff and captures the
//    request; the update and the response register load follow in ST_UPDATE,
//    which holds while the response register is full. Only one request is in
//    flight: a new one is taken after the write-back of the same entry.
//  - Reset: synchronous, active high. After reset the block sweeps the
//    1024-entry table, one entry per cycle; req_if.ready stays low during
//    the sweep.
//  - Stall: the response sits in an output register. A new request is still
//    accepted while it waits; its update then holds until rsp_if.ready
//    frees the register.
`default_nettype none

`include "tagged_btb_two_bit_predictor_top_assert.svh"

module tagged_btb_two_bit_predictor_top
   import tbtb_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   tbtb_req_if.sink   req_if,
   tbtb_rsp_if.source rsp_if
);

   cmd_type    cmd;
   status_type status;
   rsp_type    rsp_word;
   logic       ctrl_ready;
   logic       rsp_valid;

   tbtb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ctrl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tbtb_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_branch_address (req_if.branch_address),
      .req_taken          (req_if.taken),
      .rsp_ready          (rsp_if.ready),
      .rsp_valid          (rsp_valid),
      .rsp_word           (rsp_word)
   );

   assign req_if.ready              = ctrl_ready;
   assign rsp_if.valid              = rsp_valid;
   assign rsp_if.predicted_taken    = rsp_word.predicted_taken;
   assign rsp_if.hit                = rsp_word.hit;
   assign rsp_if.prediction_correct = rsp_word.prediction_correct;
   assign rsp_if.evicted            = rsp_word.evicted;
   assign rsp_if.seen_total         = rsp_word.seen_total;
   assign rsp_if.taken_total        = rsp_word.taken_total;
   assign rsp_if.correct_total      = rsp_word.correct_total;
   assign rsp_if.evicted_total      = rsp_word.evicted_total;
   assign rsp_if.entry_evictions    = rsp_word.entry_evictions;

   // commit never overwrites an unconsumed response
   `TBTB_ASSERT_NOW(a_commit_free, clock, reset, cmd.commit, status.out_free)
   // one request in flight: no accept right after an accept
   `TBTB_ASSERT_NEXT(a_one_inflight, clock, reset, cmd.capture, !req_if.ready)
   // commit loads the response register
   `TBTB_ASSERT_NEXT(a_commit_rsp, clock, reset, cmd.commit, rsp_if.valid)
   // no requests accepted during the clearing sweep
   `TBTB_ASSERT_NOW(a_clear_excl, clock, reset, cmd.clear, !req_if.ready && !cmd.commit)

endmodule

`default_nettype wire
